// File: sv/sdq_pkg.sv
package sdq_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic ins;        // insert transfer, store not full
        logic pop_front;  // remove at the small-key end, store not empty
        logic any_gt;     // some stored key is greater than the new key
        logic gt0;        // first stored key is greater than the new key
    } cell_ctl_t;

endpackage

// File: sv/sdq_cell.sv
module sdq_cell #(
    parameter int KEY_BITS    = sdq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = sdq_pkg::HANDLE_BITS_DEF,
    parameter int CNT_W       = 7,
    parameter int IDX         = 0
) (
    input  logic                   clk,
    input  sdq_pkg::cell_ctl_t     ctl,
    input  logic [CNT_W-1:0]       count,
    input  logic [KEY_BITS-1:0]    new_key,
    input  logic [HANDLE_BITS-1:0] new_handle,
    input  logic                   sel_prev,
    input  logic [KEY_BITS-1:0]    prev_key,
    input  logic [HANDLE_BITS-1:0] prev_handle,
    input  logic [KEY_BITS-1:0]    succ_key,
    input  logic [HANDLE_BITS-1:0] succ_handle,
    output logic [KEY_BITS-1:0]    key,
    output logic [HANDLE_BITS-1:0] handle,
    output logic                   gt,
    output logic                   sel
);

    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic                   occupied;
    logic                   ge;

    assign occupied = CNT_W'(IDX) < count;
    assign gt       = occupied && (key_reg > new_key);
    assign ge       = occupied && (key_reg >= new_key);

    // sel: this slot is at or past the insert point
    always_comb
    begin
        if (!occupied)
            sel = 1'b1;
        else if (!ctl.any_gt)
            sel = 1'b0;          // append
        else if (ctl.gt0)
            sel = 1'b1;          // prepend
        else if (IDX == 0)
            sel = 1'b0;
        else
            sel = ge;
    end

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctl.ins && sel)
        begin
            if (sel_prev)
            begin
                key_next    = prev_key;
                handle_next = prev_handle;
            end
            else
            begin
                key_next    = new_key;
                handle_next = new_handle;
            end
        end
        else if (ctl.pop_front)
        begin
            key_next    = succ_key;
            handle_next = succ_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign key    = key_reg;
    assign handle = handle_reg;

endmodule

// File: sv/sorted_deque_insert_pop_top.sv
// Channel  Ports                                     Transfer
// -------  ----------------------------------------  ------------------------
// command  start, busy, op, key, item_handle,        edge with start && !busy
//          from_front
// result   done, status, out_key, out_handle, count  edge ending a done cycle
//
// One command per cycle; its result strobes on done in the next cycle.
// The rate is set by the row of DEPTH cells: every cell compares its key with
// the new key and shifts from its neighbor in the same cycle.
// busy is never raised. Results cannot be stalled; done is high in each cycle that carries a result.
// Reset clears the entry count and done; cell contents are don't-care.
module sorted_deque_insert_pop_top #(
    parameter int   DEPTH       = sdq_pkg::DEPTH_DEF,
    parameter int   KEY_BITS    = sdq_pkg::KEY_BITS_DEF,
    parameter int   HANDLE_BITS = sdq_pkg::HANDLE_BITS_DEF,
    localparam int  CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   op,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [HANDLE_BITS-1:0] item_handle,
    input  logic                   from_front,
    output logic                   done,
    output logic [1:0]             status,
    output logic [KEY_BITS-1:0]    out_key,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [CNT_W-1:0]       count
);

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   done_reg;
    sdq_pkg::status_t       status_reg, status_next;
    logic [KEY_BITS-1:0]    out_key_reg, out_key_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;

    logic [KEY_BITS-1:0]    cell_key    [DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
    logic [DEPTH-1:0]       gt_vec;
    logic [DEPTH-1:0]       sel_vec;
    logic [KEY_BITS-1:0]    tail_key;
    logic [HANDLE_BITS-1:0] tail_handle;

    sdq_pkg::cell_ctl_t     ctl;
    logic                   full;
    logic                   empty;
    logic                   is_ins;
    logic                   is_rem;

    assign busy   = 1'b0;
    assign full   = count_reg == CNT_W'(DEPTH);
    assign empty  = count_reg == '0;
    assign is_ins = start && (op == sdq_pkg::OP_INSERT);
    assign is_rem = start && (op == sdq_pkg::OP_REMOVE);

    assign ctl.ins       = is_ins && !full;
    assign ctl.pop_front = is_rem && !empty && from_front;
    assign ctl.any_gt    = |gt_vec;
    assign ctl.gt0       = gt_vec[0];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [KEY_BITS-1:0]    p_key, s_key;
        logic [HANDLE_BITS-1:0] p_handle, s_handle;
        logic                   p_sel;

        if (g == 0)
        begin : g_first
            assign p_key    = '0;
            assign p_handle = '0;
            assign p_sel    = 1'b0;
        end
        else
        begin : g_mid
            assign p_key    = cell_key[g-1];
            assign p_handle = cell_handle[g-1];
            assign p_sel    = sel_vec[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign s_key    = '0;
            assign s_handle = '0;
        end
        else
        begin : g_inner
            assign s_key    = cell_key[g+1];
            assign s_handle = cell_handle[g+1];
        end

        sdq_cell #(
            .KEY_BITS   (KEY_BITS),
            .HANDLE_BITS(HANDLE_BITS),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .new_key    (key),
            .new_handle (item_handle),
            .sel_prev   (p_sel),
            .prev_key   (p_key),
            .prev_handle(p_handle),
            .succ_key   (s_key),
            .succ_handle(s_handle),
            .key        (cell_key[g]),
            .handle     (cell_handle[g]),
            .gt         (gt_vec[g]),
            .sel        (sel_vec[g])
        );
    end

    // AND-OR select of the last occupied cell
    always_comb
    begin
        tail_key    = '0;
        tail_handle = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (count_reg == CNT_W'(i + 1))
            begin
                tail_key    = tail_key | cell_key[i];
                tail_handle = tail_handle | cell_handle[i];
            end
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        status_next     = sdq_pkg::STAT_DONE;
        out_key_next    = '0;
        out_handle_next = '0;
        if (is_ins)
        begin
            if (full)
                status_next = sdq_pkg::STAT_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (is_rem)
        begin
            if (empty)
                status_next = sdq_pkg::STAT_EMPTY;
            else
            begin
                count_next = count_reg - CNT_W'(1);
                if (from_front)
                begin
                    out_key_next    = cell_key[0];
                    out_handle_next = cell_handle[0];
                end
                else
                begin
                    out_key_next    = tail_key;
                    out_handle_next = tail_handle;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg     <= status_next;
            out_key_reg    <= out_key_next;
            out_handle_reg <= out_handle_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_key    = out_key_reg;
    assign out_handle = out_handle_reg;
    assign count      = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == sdq_pkg::STAT_FULL) |-> count_reg == CNT_W'(DEPTH))
        else $error("full reject while not full");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == sdq_pkg::STAT_EMPTY) |-> count_reg == '0)
        else $error("empty reject while not empty");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != sdq_pkg::STAT_DONE)
            |-> (out_key_reg == '0) && (out_handle_reg == '0))
        else $error("rejected transfer returned data");

endmodule

// File: tb/tb_sorted_deque_insert_pop_top.sv
module tb_sorted_deque_insert_pop_top;

    localparam int KW          = sdq_pkg::KEY_BITS_DEF;
    localparam int HW          = sdq_pkg::HANDLE_BITS_DEF;
    localparam int NCELLS      = sdq_pkg::DEPTH_DEF;
    localparam int CW          = $clog2(NCELLS + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_BOUND = 1000;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_mode_t;
    typedef enum {KEYS_FEW, KEYS_ANY, KEYS_LOW} key_mode_t;

    typedef struct {
        sdq_pkg::status_t status;
        logic [KW-1:0]    key;
        logic [HW-1:0]    handle;
        logic [CW-1:0]    count;
    } deque_result_t;

    // Tracks the sorted store contents and the results still owed by the block.
    class deque_tracker;
        bit [KW-1:0]   key_row[NCELLS];
        bit [HW-1:0]   handle_row[NCELLS];
        int            fill;
        deque_result_t pending[$];
        int            mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_command(input logic c_op, input logic [KW-1:0] c_key,
                                   input logic [HW-1:0] c_handle, input logic c_front);
            deque_result_t r;
            int            slot;
            int            i;
            r.status = sdq_pkg::STAT_DONE;
            r.key    = '0;
            r.handle = '0;
            if (c_op == sdq_pkg::OP_INSERT)
            begin
                if (fill >= NCELLS)
                begin
                    r.status = sdq_pkg::STAT_FULL;
                end
                else
                begin
                    if (fill == 0)
                        slot = 0;
                    else if (key_row[fill-1] <= c_key)
                        slot = fill;
                    else if (key_row[0] > c_key)
                        slot = 0;
                    else
                    begin
                        // search starts at position one, so a tie with the head lands after it
                        slot = fill;
                        for (i = 1; i < fill; i++)
                            if (slot == fill && key_row[i] >= c_key)
                                slot = i;
                    end
                    for (i = fill; i > slot; i--)
                    begin
                        key_row[i]    = key_row[i-1];
                        handle_row[i] = handle_row[i-1];
                    end
                    key_row[slot]    = c_key;
                    handle_row[slot] = c_handle;
                    fill++;
                end
            end
            else
            begin
                if (fill == 0)
                begin
                    r.status = sdq_pkg::STAT_EMPTY;
                end
                else if (c_front)
                begin
                    r.key    = key_row[0];
                    r.handle = handle_row[0];
                    for (i = 1; i < fill; i++)
                    begin
                        key_row[i-1]    = key_row[i];
                        handle_row[i-1] = handle_row[i];
                    end
                    fill--;
                end
                else
                begin
                    r.key    = key_row[fill-1];
                    r.handle = handle_row[fill-1];
                    fill--;
                end
            end
            r.count = fill[CW-1:0];
            pending.push_back(r);
        endfunction

        task check_result(input logic [1:0] g_status, input logic [KW-1:0] g_key,
                          input logic [HW-1:0] g_handle, input logic [CW-1:0] g_count);
            deque_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result strobe with no command outstanding");
            end
            else
            begin
                want = pending.pop_front();
                if (g_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", g_status, want.status));
                if (g_key !== want.key)
                    report_mismatch($sformatf("out_key %h, want %h", g_key, want.key));
                if (g_handle !== want.handle)
                    report_mismatch($sformatf("out_handle %h, want %h", g_handle, want.handle));
                if (g_count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d", g_count, want.count));
            end
        endtask
    endclass

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          start       = 1'b0;
    logic          op          = sdq_pkg::OP_INSERT;
    logic [KW-1:0] key         = '0;
    logic [HW-1:0] item_handle = '0;
    logic          from_front  = 1'b0;
    logic          busy;
    logic          done;
    logic [1:0]    status;
    logic [KW-1:0] out_key;
    logic [HW-1:0] out_handle;
    logic [CW-1:0] count;

    int            cycles = 0;
    deque_tracker  tracker = new();

    sorted_deque_insert_pop_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .key         (key),
        .item_handle (item_handle),
        .from_front  (from_front),
        .done        (done),
        .status      (status),
        .out_key     (out_key),
        .out_handle  (out_handle),
        .count       (count)
    );

    always #10 clk = ~clk;

    // note the command first so a same-edge result still finds its expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_command(op, key, item_handle, from_front);
            if (done)
                tracker.check_result(status, out_key, out_handle, count);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_cmd(input logic c_op, input logic [KW-1:0] c_key,
                            input logic [HW-1:0] c_handle, input logic c_front);
        start       <= 1'b1;
        op          <= c_op;
        key         <= c_key;
        item_handle <= c_handle;
        from_front  <= c_front;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // inputs carry junk while start is low
    task automatic idle_cycles(input int n);
        start       <= 1'b0;
        op          <= 1'($urandom_range(0, 1));
        key         <= KW'($urandom);
        item_handle <= HW'($urandom);
        from_front  <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0 && n < DRAIN_BOUND)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic random_phase(input phase_mode_t mode, input int n_items,
                                input bit allow_idle);
        int            ins_pct;
        key_mode_t     kmode;
        logic [KW-1:0] k;
        logic          c_op;
        case (mode)
            PH_FILL:  ins_pct = 85;
            PH_DRAIN: ins_pct = 15;
            default:  ins_pct = 50;
        endcase
        kmode = key_mode_t'($urandom_range(0, 2));
        for (int i = 0; i < n_items; i++)
        begin
            case (kmode)
                KEYS_FEW: k = KW'($urandom_range(0, 3) * 16'h5555);  // heavy ties, both extremes
                KEYS_LOW: k = KW'($urandom_range(0, 15));
                default:  k = KW'($urandom);
            endcase
            c_op = ($urandom_range(0, 99) < ins_pct) ? sdq_pkg::OP_INSERT : sdq_pkg::OP_REMOVE;
            send_cmd(c_op, k, HW'($urandom), 1'($urandom_range(0, 1)));
            if (allow_idle && $urandom_range(0, 5) == 0)
                idle_cycles($urandom_range(1, 14));
        end
    endtask

    initial
    begin
        int issued;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty removes, placement rules, ties, ignored fields, drain to empty
        send_cmd(sdq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 1'b1);
        send_cmd(sdq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF, 1'b0);
        send_cmd(sdq_pkg::OP_INSERT, 16'h8000, 16'h0001, 1'b0);
        send_cmd(sdq_pkg::OP_INSERT, 16'h8000, 16'h0002, 1'b0);
        send_cmd(sdq_pkg::OP_INSERT, 16'h0000, 16'hFFFF, 1'b0);
        send_cmd(sdq_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 1'b1);
        send_cmd(sdq_pkg::OP_INSERT, 16'h0000, 16'h1234, 1'b0);
        send_cmd(sdq_pkg::OP_INSERT, 16'h8000, 16'h0003, 1'b1);
        send_cmd(sdq_pkg::OP_INSERT, 16'h4000, 16'h0004, 1'b0);
        send_cmd(sdq_pkg::OP_INSERT, 16'hFFFF, 16'hAAAA, 1'b0);
        send_cmd(sdq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 1'b1);
        send_cmd(sdq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 1'b0);
        send_cmd(sdq_pkg::OP_REMOVE, 16'hA5A5, 16'h5A5A, 1'b1);
        send_cmd(sdq_pkg::OP_INSERT, 16'h5555, 16'h5555, 1'b1);
        idle_cycles(3);
        for (int i = 0; i < 6; i++)
            send_cmd(sdq_pkg::OP_REMOVE, 16'h0000, 16'h0000, i[0]);
        send_cmd(sdq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 1'b1);

        wait_drained();

        // fill past full, then drain past empty
        random_phase(PH_FILL, 120, 1'b1);
        random_phase(PH_DRAIN, 120, 1'b1);
        issued = 240;
        while (issued < 1500)
        begin
            n = $urandom_range(60, 140);
            random_phase(phase_mode_t'($urandom_range(0, 2)), n, $urandom_range(0, 3) != 0);
            issued += n;
            if ($urandom_range(0, 2) == 0)
                wait_drained();
        end
        // back-to-back transfers to the end
        random_phase(PH_MIXED, 250, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.pending.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending.size()));
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
